// ===== hw/rtl/bls_pkg.sv =====
// Package for the line stepper: operation codes and the line control flags.
// No dependencies; imported by every module of the block.
package bls_pkg;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// Control flags of the line in progress
	typedef struct packed {
		logic minor_down;
		logic steep_line;
		logic dash_mode;
		logic line_active;
	} line_flags_t;

endpackage

// ===== hw/rtl/bls_setup.sv =====
// Line setup: axis swap, endpoint ordering, deltas and initial error term.
// Depends on bls_pkg.
module bls_setup import bls_pkg::*; #(
	parameter int COORD_WIDTH = 8
) (
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	input  logic                   dashed,
	output logic [COORD_WIDTH-1:0] major_pos,
	output logic [COORD_WIDTH-1:0] minor_pos,
	output logic [COORD_WIDTH-1:0] major_end,
	output logic [COORD_WIDTH-1:0] delta_major,
	output logic [COORD_WIDTH-1:0] delta_minor,
	output logic [COORD_WIDTH:0]   error_term,
	output line_flags_t            flags
);

	logic [COORD_WIDTH-1:0] dx, dy;
	logic [COORD_WIDTH-1:0] a_maj, a_min, b_maj, b_min;
	logic [COORD_WIDTH-1:0] lo_maj, lo_min, hi_maj, hi_min;
	logic                   steep;

	always_comb begin
		dx    = (start_x > end_x) ? start_x - end_x : end_x - start_x;
		dy    = (start_y > end_y) ? start_y - end_y : end_y - start_y;
		steep = dy > dx;
		a_maj = steep ? start_y : start_x;
		a_min = steep ? start_x : start_y;
		b_maj = steep ? end_y   : end_x;
		b_min = steep ? end_x   : end_y;
		// order the endpoints so the major coordinate rises
		if (a_maj > b_maj) begin
			lo_maj = b_maj;
			lo_min = b_min;
			hi_maj = a_maj;
			hi_min = a_min;
		end else begin
			lo_maj = a_maj;
			lo_min = a_min;
			hi_maj = b_maj;
			hi_min = b_min;
		end
	end

	assign major_pos         = lo_maj;
	assign minor_pos         = lo_min;
	assign major_end         = hi_maj;
	assign delta_major       = hi_maj - lo_maj;
	assign delta_minor       = (lo_min > hi_min) ? lo_min - hi_min : hi_min - lo_min;
	assign error_term        = {2'b00, delta_major[COORD_WIDTH-1:1]};
	assign flags.minor_down  = !(lo_min < hi_min);
	assign flags.steep_line  = steep;
	assign flags.dash_mode   = dashed;
	assign flags.line_active = lo_maj < hi_maj;

endmodule

// ===== hw/rtl/bls_step.sv =====
// One Bresenham iteration: current pixel, draw and last bits, next position.
// Depends on bls_pkg.
module bls_step import bls_pkg::*; #(
	parameter int COORD_WIDTH = 8
) (
	input  logic [COORD_WIDTH-1:0] major_pos,
	input  logic [COORD_WIDTH-1:0] minor_pos,
	input  logic [COORD_WIDTH-1:0] major_end,
	input  logic [COORD_WIDTH-1:0] delta_major,
	input  logic [COORD_WIDTH-1:0] delta_minor,
	input  logic [COORD_WIDTH:0]   error_term,
	input  line_flags_t            flags,
	output logic [COORD_WIDTH-1:0] pixel_x,
	output logic [COORD_WIDTH-1:0] pixel_y,
	output logic                   draw,
	output logic                   last,
	output logic [COORD_WIDTH-1:0] major_next,
	output logic [COORD_WIDTH-1:0] minor_next,
	output logic [COORD_WIDTH:0]   error_next
);

	logic signed [COORD_WIDTH:0] err_dec;

	always_comb begin
		err_dec = $signed(error_term) - $signed({1'b0, delta_minor});
		if (err_dec[COORD_WIDTH]) begin
			error_next = err_dec + {1'b0, delta_major};
			minor_next = flags.minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
		end else begin
			error_next = err_dec;
			minor_next = minor_pos;
		end
	end

	assign major_next = major_pos + 1'b1;
	assign last       = major_next == major_end;
	assign pixel_x    = flags.steep_line ? minor_pos : major_pos;
	assign pixel_y    = flags.steep_line ? major_pos : minor_pos;
	assign draw       = !flags.dash_mode || !major_pos[0];

endmodule

// ===== hw/rtl/bresenham_line_stepper.sv =====
// Bresenham line stepper: a start transaction loads a line, step transactions emit pixels.
// Step pixels pass the input register stage, then the result register, and show on strobe.
// Throughput: one transaction per cycle, set by the single add-compare-update on the state.
// Reset: asynchronous, active low; clears line state; busy is high until ready_q is set.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module bresenham_line_stepper import bls_pkg::*; #(
	parameter int COORD_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   operation,
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	input  logic                   dashed,
	output logic                   strobe,
	output logic [COORD_WIDTH-1:0] pixel_x,
	output logic [COORD_WIDTH-1:0] pixel_y,
	output logic                   draw,
	output logic                   last
);

	// Input register stage
	logic                   valid_s1;
	op_t                    op_s1;
	logic [COORD_WIDTH-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic                   dashed_s1;

	// Line state
	logic [COORD_WIDTH-1:0] major_pos_q, minor_pos_q, major_end_q;
	logic [COORD_WIDTH-1:0] delta_major_q, delta_minor_q;
	logic [COORD_WIDTH:0]   error_term_q;
	line_flags_t            flags_q;

	// Result register
	logic                   strobe_q;
	logic [COORD_WIDTH-1:0] pixel_x_q, pixel_y_q;
	logic                   draw_q, last_q;
	logic                   ready_q;

	// Setup outputs
	logic [COORD_WIDTH-1:0] su_major_pos, su_minor_pos, su_major_end;
	logic [COORD_WIDTH-1:0] su_delta_major, su_delta_minor;
	logic [COORD_WIDTH:0]   su_error_term;
	line_flags_t            su_flags;

	// Step outputs
	logic [COORD_WIDTH-1:0] st_pixel_x, st_pixel_y;
	logic                   st_draw, st_last;
	logic [COORD_WIDTH-1:0] st_major_next, st_minor_next;
	logic [COORD_WIDTH:0]   st_error_next;

	logic accept;

	// Hold off transactions after reset release until the ready register is set
	assign busy   = !ready_q;
	assign accept = start && ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			ready_q  <= 1'b1;
			valid_s1 <= accept;
		end
	end

	// Capture the transaction payload; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(operation);
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
			dashed_s1  <= dashed;
		end
	end

	bls_setup #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_setup (
		.start_x    (start_x_s1),
		.start_y    (start_y_s1),
		.end_x      (end_x_s1),
		.end_y      (end_y_s1),
		.dashed     (dashed_s1),
		.major_pos  (su_major_pos),
		.minor_pos  (su_minor_pos),
		.major_end  (su_major_end),
		.delta_major(su_delta_major),
		.delta_minor(su_delta_minor),
		.error_term (su_error_term),
		.flags      (su_flags)
	);

	bls_step #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_step (
		.major_pos  (major_pos_q),
		.minor_pos  (minor_pos_q),
		.major_end  (major_end_q),
		.delta_major(delta_major_q),
		.delta_minor(delta_minor_q),
		.error_term (error_term_q),
		.flags      (flags_q),
		.pixel_x    (st_pixel_x),
		.pixel_y    (st_pixel_y),
		.draw       (st_draw),
		.last       (st_last),
		.major_next (st_major_next),
		.minor_next (st_minor_next),
		.error_next (st_error_next)
	);

	// Update the line state: a start replaces any line, a step advances an active one.
	// A step with no active line is dropped without a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			major_end_q   <= '0;
			delta_major_q <= '0;
			delta_minor_q <= '0;
			error_term_q  <= '0;
			flags_q       <= '0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (valid_s1) begin
				case (op_s1)
					OP_START: begin
						major_pos_q   <= su_major_pos;
						minor_pos_q   <= su_minor_pos;
						major_end_q   <= su_major_end;
						delta_major_q <= su_delta_major;
						delta_minor_q <= su_delta_minor;
						error_term_q  <= su_error_term;
						flags_q       <= su_flags;
					end
					OP_STEP: begin
						if (flags_q.line_active) begin
							major_pos_q         <= st_major_next;
							minor_pos_q         <= st_minor_next;
							error_term_q        <= st_error_next;
							flags_q.line_active <= !st_last;
							strobe_q            <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result payload, qualified by strobe
	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1 == OP_STEP && flags_q.line_active) begin
			pixel_x_q <= st_pixel_x;
			pixel_y_q <= st_pixel_y;
			draw_q    <= st_draw;
			last_q    <= st_last;
		end
	end

	assign strobe  = strobe_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign draw    = draw_q;
	assign last    = last_q;

endmodule

// ===== hw/rtl/bls_checker.sv =====
// Port-level checks on the line stepper, bound to the top level.
// Depends on bls_pkg and bresenham_line_stepper.
module bls_checker import bls_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic strobe,
	input logic last
);

	// A result only follows an accepted step transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy && operation == OP_STEP, 2))
		else $error("result without a step transaction");

	// A start transaction never yields a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_START) |-> ##2 !strobe)
		else $error("result from a start transaction");

	// Nothing follows the last pixel of a line in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("result directly after the last pixel");

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operation(operation),
	.strobe   (strobe),
	.last     (last)
);
